### rtl/snrm_pkg.sv
package snrm_pkg;

  localparam int DWELL_W = 24;
  localparam int SPIKE_W = 16;
  localparam int RATE_W  = 32;
  localparam int POSF_W  = 6;
  // eight surround bins at most
  localparam int SSUM_W  = SPIKE_W + 3;
  localparam int TSUM_W  = DWELL_W + 3;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 7;

  localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT = 2'd1;

  typedef struct packed {
    logic [DWELL_W-1:0] dwell;
    logic [SPIKE_W-1:0] spikes;
    logic [RATE_W-1:0]  rate;
  } cell_t;

  typedef struct packed {
    logic [POSF_W-1:0] row;
    logic [POSF_W-1:0] col;
    logic [RATE_W-1:0] own;
    logic [RATE_W-1:0] nbr;
  } res_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_SHIFT,
    S_SUM,
    S_CHECK,
    S_DIV,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic read;
    logic shift;
    logic sum;
    logic div_start;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_done;
    logic emit_block;
  } status_t;

endpackage

### rtl/snrm_if.sv
interface snrm_in_if import snrm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               func;
  logic [DWELL_W-1:0] dwell_time;
  logic [SPIKE_W-1:0] spike_count;
  logic [RATE_W-1:0]  rate_value;
  modport source (output valid, func, dwell_time, spike_count, rate_value, input ready);
  modport sink (input valid, func, dwell_time, spike_count, rate_value, output ready);
endinterface

interface snrm_out_if import snrm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [POSF_W-1:0] bin_row;
  logic [POSF_W-1:0] bin_col;
  logic [RATE_W-1:0] own_rate;
  logic [RATE_W-1:0] neighbour_rate;
  logic              frame_last;
  modport source (output valid, bin_row, bin_col, own_rate, neighbour_rate, frame_last,
                  input ready);
  modport sink (input valid, bin_row, bin_col, own_rate, neighbour_rate, frame_last,
                output ready);
endinterface

interface snrm_cfg_if import snrm_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### rtl/snrm_div.sv
module snrm_div import snrm_pkg::*; #(
  parameter int NUM_W = 44,
  parameter int DEN_W = 28
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [NUM_W-1:0] quot,
  output logic             done
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] dvd_r, dvd_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;

  // restoring division, one quotient bit per cycle
  always_comb begin
    trial    = {rem_r, dvd_r[NUM_W-1]};
    diff     = trial - {1'b0, den_r};
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = done_r;
    if (start) begin
      dvd_nxt  = num;
      rem_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = diff[DEN_W-1:0];
        dvd_nxt = {dvd_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DEN_W-1:0];
        dvd_nxt = {dvd_r[NUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(NUM_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    if (start) den_r <= den;
  end

  assign quot = dvd_r;
  assign done = done_r;

endmodule

### rtl/snrm_dp.sv
module snrm_dp import snrm_pkg::*; #(
  parameter int MAX_WIDTH      = 64,
  parameter int MAX_HEIGHT     = 64,
  parameter int TIME_FRAC_BITS = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cmd_t                 cmd,
  output status_t              status,
  input  logic                 in_func,
  input  logic [DWELL_W-1:0]   in_dwell_time,
  input  logic [SPIKE_W-1:0]   in_spike_count,
  input  logic [RATE_W-1:0]    in_rate_value,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [POSF_W-1:0]    out_bin_row,
  output logic [POSF_W-1:0]    out_bin_col,
  output logic [RATE_W-1:0]    out_own_rate,
  output logic [RATE_W-1:0]    out_neighbour_rate,
  output logic                 out_frame_last,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int CLW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int POS_W = $clog2(MAX_WIDTH * MAX_HEIGHT + MAX_WIDTH + 1);
  localparam int SHIFT = TIME_FRAC_BITS + 17;
  localparam int NUM_W = SSUM_W + SHIFT;
  localparam int DEN_W = TSUM_W + 1;

  logic [CFG_DAT_W-1:0] map_w_r, map_h_r;
  logic [WW-1:0]        w_eff;
  logic [HW-1:0]        h_eff;
  logic [POS_W-1:0]     total, limit_end, wp1, pdist;

  logic [POS_W-1:0] n_r, last_pos_r;
  logic [CLW-1:0]   c_r, pcol_r;
  logic [RW-1:0]    prow_r;
  logic             visited_r, held_valid_r;
  res_t             held_r;
  cell_t            cur_r;
  cell_t            win_r [3][3];
  cell_t            up_rd_r, md_rd_r;
  cell_t            upper_mem [MAX_WIDTH];
  cell_t            middle_mem [MAX_WIDTH];
  logic [SSUM_W-1:0] s_r;
  logic [TSUM_W-1:0] t_r;

  logic             out_valid_r;
  res_t             out_res_r;
  logic             out_last_r;

  logic [NUM_W-1:0] quot;
  logic             div_done;
  logic [RATE_W-1:0] nbr_val;

  logic             cfg_hit;

  assign cfg_ready = 1'b1;
  assign cfg_hit   = cfg_valid && (cfg_index == REG_MAP_WIDTH || cfg_index == REG_MAP_HEIGHT);

  always_comb begin
    if (map_w_r < CFG_DAT_W'(2))            w_eff = WW'(2);
    else if (32'(map_w_r) > MAX_WIDTH)      w_eff = WW'(MAX_WIDTH);
    else                                    w_eff = WW'(map_w_r);
    if (map_h_r < CFG_DAT_W'(2))            h_eff = HW'(2);
    else if (32'(map_h_r) > MAX_HEIGHT)     h_eff = HW'(MAX_HEIGHT);
    else                                    h_eff = HW'(map_h_r);
  end

  assign total     = POS_W'(w_eff) * POS_W'(h_eff);
  assign limit_end = total + POS_W'(w_eff);
  assign wp1       = POS_W'(w_eff) + POS_W'(1);
  assign pdist     = n_r - wp1;

  // line stores: read in one step, written back in the next
  always_ff @(posedge clk) begin
    if (cmd.read) begin
      up_rd_r <= upper_mem[c_r];
      md_rd_r <= middle_mem[c_r];
    end
    if (cmd.shift) begin
      upper_mem[c_r]  <= md_rd_r;
      middle_mem[c_r] <= cur_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < 3; r++)
        for (int k = 0; k < 3; k++)
          win_r[r][k] <= '0;
    end else if (cmd.shift) begin
      for (int r = 0; r < 3; r++) begin
        win_r[r][0] <= win_r[r][1];
        win_r[r][1] <= win_r[r][2];
      end
      win_r[0][2] <= up_rd_r;
      win_r[1][2] <= md_rd_r;
      win_r[2][2] <= cur_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      if (!in_func && n_r < total) begin
        cur_r.dwell  <= in_dwell_time;
        cur_r.spikes <= in_spike_count;
        cur_r.rate   <= in_rate_value;
      end else begin
        cur_r <= '0;
      end
    end
  end

  // masked surround sums, center and off-map bins dropped
  logic [2:0]        rv, cv;
  logic [SSUM_W-1:0] s_sum;
  logic [TSUM_W-1:0] t_sum;

  always_comb begin
    rv[0] = (prow_r != '0);
    rv[1] = 1'b1;
    rv[2] = (HW'(prow_r) + HW'(1)) < h_eff;
    cv[0] = (pcol_r != '0);
    cv[1] = 1'b1;
    cv[2] = (WW'(pcol_r) + WW'(1)) < w_eff;
    s_sum = '0;
    t_sum = '0;
    for (int r = 0; r < 3; r++)
      for (int k = 0; k < 3; k++)
        if (rv[r] && cv[k] && !(r == 1 && k == 1)) begin
          s_sum = s_sum + SSUM_W'(win_r[r][k].spikes);
          t_sum = t_sum + TSUM_W'(win_r[r][k].dwell);
        end
  end

  always_ff @(posedge clk) begin
    if (cmd.sum) begin
      s_r <= s_sum;
      t_r <= t_sum;
    end
  end

  snrm_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   ((NUM_W'(s_r) << SHIFT) + NUM_W'(t_r)),
    .den   ({t_r, 1'b0}),
    .quot  (quot),
    .done  (div_done)
  );

  always_comb begin
    if (t_r == '0)                  nbr_val = '0;
    else if (|quot[NUM_W-1:RATE_W]) nbr_val = '1;
    else                            nbr_val = quot[RATE_W-1:0];
  end

  // result selection for the current item
  logic             cur_vis, vis_new, rel, res_ok, direct, endf, held_mid_valid, has_out;
  logic [POS_W-1:0] last_new;
  res_t             res, held_mid, out_sel;
  logic             out_sel_last;
  logic             out_load;

  always_comb begin
    cur_vis  = (cur_r.dwell != '0);
    vis_new  = visited_r | cur_vis;
    last_new = cur_vis ? n_r : last_pos_r;
    rel      = cur_vis & held_valid_r;
    res_ok   = (n_r >= wp1) && (win_r[1][1].dwell != '0);
    direct   = res_ok && vis_new && (last_new > pdist);
    endf     = (n_r >= limit_end);
    res.row  = POSF_W'(prow_r);
    res.col  = POSF_W'(pcol_r);
    res.own  = win_r[1][1].rate;
    res.nbr  = nbr_val;
    held_mid_valid = (held_valid_r & ~rel) | (res_ok & ~direct);
    held_mid = (res_ok & ~direct) ? res : held_r;
    has_out  = rel | direct | (endf & held_mid_valid);
    priority if (rel) begin
      out_sel      = held_r;
      out_sel_last = 1'b0;
    end else if (direct) begin
      out_sel      = res;
      out_sel_last = 1'b0;
    end else begin
      out_sel      = held_mid;
      out_sel_last = 1'b1;
    end
  end

  assign out_load = cmd.emit && !cfg_hit && has_out;

  assign status.need_div   = (t_r != '0);
  assign status.div_done   = div_done;
  assign status.emit_block = has_out && out_valid_r && !out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_w_r      <= CFG_DAT_W'(64);
      map_h_r      <= CFG_DAT_W'(64);
      n_r          <= '0;
      c_r          <= '0;
      prow_r       <= '0;
      pcol_r       <= '0;
      last_pos_r   <= '0;
      visited_r    <= 1'b0;
      held_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      // load a new beat, else drop the current one once taken
      out_valid_r <= out_load | (out_valid_r & ~out_ready);
      if (cfg_hit) begin
        if (cfg_index == REG_MAP_WIDTH) map_w_r <= cfg_data;
        else                            map_h_r <= cfg_data;
        n_r          <= '0;
        c_r          <= '0;
        prow_r       <= '0;
        pcol_r       <= '0;
        last_pos_r   <= '0;
        visited_r    <= 1'b0;
        held_valid_r <= 1'b0;
      end else if (cmd.emit) begin
        if (endf) begin
          // frame done: restart position and drop held state
          n_r          <= '0;
          c_r          <= '0;
          prow_r       <= '0;
          pcol_r       <= '0;
          last_pos_r   <= '0;
          visited_r    <= 1'b0;
          held_valid_r <= 1'b0;
        end else begin
          held_valid_r <= held_mid_valid;
          visited_r    <= vis_new;
          last_pos_r   <= last_new;
          n_r          <= n_r + POS_W'(1);
          if (WW'(c_r) + WW'(1) >= w_eff) c_r <= '0;
          else                            c_r <= c_r + CLW'(1);
          if (n_r >= wp1) begin
            if (WW'(pcol_r) + WW'(1) >= w_eff) begin
              pcol_r <= '0;
              prow_r <= prow_r + RW'(1);
            end else begin
              pcol_r <= pcol_r + CLW'(1);
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      held_r <= held_mid;
      if (has_out) begin
        out_res_r  <= out_sel;
        out_last_r <= out_sel_last;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_bin_row        = out_res_r.row;
  assign out_bin_col        = out_res_r.col;
  assign out_own_rate       = out_res_r.own;
  assign out_neighbour_rate = out_res_r.nbr;
  assign out_frame_last     = out_last_r;

`ifndef SYNTHESIS
  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> t_r != '0)
    else $error("divide started with zero surround time");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit && has_out |-> !(out_valid_r && !out_ready))
    else $error("result loaded over a waiting beat");
  a_frame_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit && endf && !cfg_hit |=> !held_valid_r && n_r == '0)
    else $error("frame end did not restart");
`endif

endmodule

### rtl/snrm_ctrl.sv
module snrm_ctrl import snrm_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_READ;
      S_READ:  state_nxt = S_SHIFT;
      S_SHIFT: state_nxt = S_SUM;
      S_SUM:   state_nxt = S_CHECK;
      S_CHECK: state_nxt = status.need_div ? S_DIV : S_EMIT;
      S_DIV:   if (status.div_done) state_nxt = S_EMIT;
      S_EMIT:  if (!status.emit_block) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_READ:  cmd.read = 1'b1;
      S_SHIFT: cmd.shift = 1'b1;
      S_SUM:   cmd.sum = 1'b1;
      S_CHECK: cmd.div_start = status.need_div;
      S_DIV:   cmd = '0;
      S_EMIT:  cmd.emit = !status.emit_block;
      default: cmd = '0;
    endcase
  end

endmodule

### rtl/spatial_neighbour_rate_map.sv
// Neighbour-rate map for 2-D rate maps streamed in raster order.
// in_bus: one beat per map bin (func 0) with dwell, spike count and rate;
//   after the frame's last bin send map_width+1 flush beats (func 1).
// out_bus: one beat per bin with nonzero dwell: position, own rate and the
//   3x3 surround rate (spikes over dwell, center and off-map bins dropped,
//   16 fractional bits, saturated, 0 when surround dwell is 0).
// cfg_bus: index 0 = map_width, 1 = map_height, clamped to 2..MAX; a write
//   restarts the frame. Write only while no beat is in flight.
// Sequence: each input beat steps through read, shift, sum, check and emit,
//   with a divide step after check when a surround divide is needed, in which
//   the block waits for the bit-serial restoring divider. Results trail their bin
//   by one row plus one bin of input beats.
// The output register holds a finished beat while the next input beat is
//   processed; if a new result is ready and out_bus is stalled, the block
//   waits and holds in_bus.ready low.
// Reset: sizes return to 64x64, the frame position and held result clear;
//   line stores hold nothing valid until a frame writes them.
module spatial_neighbour_rate_map import snrm_pkg::*; #(
  parameter int MAX_WIDTH      = 64,
  parameter int MAX_HEIGHT     = 64,
  parameter int TIME_FRAC_BITS = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  snrm_in_if.sink    in_bus,
  snrm_out_if.source out_bus,
  snrm_cfg_if.sink   cfg_bus
);

  cmd_t    cmd;
  status_t status;

  snrm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_bus.valid),
    .in_ready (in_bus.ready),
    .status   (status),
    .cmd      (cmd)
  );

  snrm_dp #(
    .MAX_WIDTH      (MAX_WIDTH),
    .MAX_HEIGHT     (MAX_HEIGHT),
    .TIME_FRAC_BITS (TIME_FRAC_BITS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .status             (status),
    .in_func            (in_bus.func),
    .in_dwell_time      (in_bus.dwell_time),
    .in_spike_count     (in_bus.spike_count),
    .in_rate_value      (in_bus.rate_value),
    .out_valid          (out_bus.valid),
    .out_ready          (out_bus.ready),
    .out_bin_row        (out_bus.bin_row),
    .out_bin_col        (out_bus.bin_col),
    .out_own_rate       (out_bus.own_rate),
    .out_neighbour_rate (out_bus.neighbour_rate),
    .out_frame_last     (out_bus.frame_last),
    .cfg_valid          (cfg_bus.valid),
    .cfg_ready          (cfg_bus.ready),
    .cfg_index          (cfg_bus.index),
    .cfg_data           (cfg_bus.data)
  );

endmodule
